// File: rtl/mbps_pkg.sv
package mbps_pkg;

	// fixed register layout: three 64-bit pattern words, 24 pattern slots
	localparam int PAT_SLOTS       = 24;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 5;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int COUNT_W         = 17;
	localparam int OFFSET_W        = 16;
	localparam int MAX_PATTERN_DEF = 24;
	localparam int MAX_BUFFER      = 65536;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_MID  = 3'd1,
		REG_PAT_HIGH = 3'd2,
		REG_CARE     = 3'd3,
		REG_LEN      = 3'd4
	} reg_idx_t;

	typedef logic [PAT_SLOTS-1:0][BYTE_W-1:0] pat_bytes_t;

	// pattern setup shared by every cell of the chain
	typedef struct packed {
		pat_bytes_t           pat;
		logic [PAT_SLOTS-1:0] care;
		logic [LEN_W-1:0]     len;
	} search_cfg_t;

endpackage

// File: rtl/mbps_cell.sv
module mbps_cell
	import mbps_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  logic [BYTE_W-1:0] byte_in,
	input  search_cfg_t       cfg,
	output logic [BYTE_W-1:0] byte_out,
	output logic              ok
);

	localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0]  sel;
	logic              in_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// this cell holds the byte that lines up with pattern byte len-1-idx
	assign in_use = IDX < cfg.len;
	assign sel    = cfg.len - IDX - LEN_W'(1);
	assign ok     = !in_use || !cfg.care[sel] || (cfg.pat[sel] == byte_q);

	assign byte_out = byte_q;

endmodule

// File: rtl/masked_byte_pattern_search_core.sv
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------
// input     | in_valid, in_stall | data_byte, last_byte
// result    | out_valid, out_stall | found, match_offset
// config    | cfg_we             | cfg_index, cfg_data
//
// one byte per cycle unless the result side stalls; the byte shifts into the
// cell chain at its accepting edge, then the decision loads the output register
// match_reported is registered in time for the next byte's compare, so no bubbles
// reset clears the window, the byte count and all valid flags
// a stalled result holds in the output register; the input stalls only when
// the compare stage also holds a result that cannot move
module masked_byte_pattern_search_core
	import mbps_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  last_byte,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [OFFSET_W-1:0]   match_offset,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PATTERN);

	// configuration registers
	pat_bytes_t           pat_q;
	logic [PAT_SLOTS-1:0] care_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_wr;
	search_cfg_t          cfg;

	// buffer state
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   count_next;
	logic                 match_reported_q;

	// compare stage
	logic                 valid_s1;
	logic                 last_s1;
	logic [COUNT_W-1:0]   count_s1;

	// output register
	logic                 out_valid_q;
	logic                 found_q;
	logic [OFFSET_W-1:0]  offset_q;

	logic                 accept;
	logic                 s1_go;
	logic                 all_ok;
	logic                 hit;
	logic                 res_s1;
	logic [COUNT_W-1:0]   start;

	logic [MAX_PATTERN:0][BYTE_W-1:0] chain;
	logic [MAX_PATTERN-1:0]           cell_ok;

	// length write clamps to 1..MAX_PATTERN
	always_comb begin
		len_wr = cfg_data[LEN_W-1:0];
		if (len_wr == '0) begin
			len_wr = LEN_W'(1);
		end else if (len_wr > LEN_CAP) begin
			len_wr = LEN_CAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			care_q <= '0;
			len_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PAT_LOW:  pat_q[7:0]   <= cfg_data;
				REG_PAT_MID:  pat_q[15:8]  <= cfg_data;
				REG_PAT_HIGH: pat_q[23:16] <= cfg_data;
				REG_CARE:     care_q       <= cfg_data[PAT_SLOTS-1:0];
				REG_LEN:      len_q        <= len_wr;
				default: ;
			endcase
		end
	end

	assign cfg.pat  = pat_q;
	assign cfg.care = care_q;
	assign cfg.len  = len_q;

	// window: a row of byte cells, newest byte in cell 0
	assign chain[0] = data_byte;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		mbps_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(accept),
			.byte_in (chain[k]),
			.cfg     (cfg),
			.byte_out(chain[k+1]),
			.ok      (cell_ok[k])
		);
	end

	assign all_ok = &cell_ok;

	// handshake: compare stage moves unless its result meets a full, stalled output
	assign s1_go    = !res_s1 || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;

	// saturating byte count, restarted after the last byte of a buffer
	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			count_q  <= last_byte ? '0 : count_next;
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= last_byte;
			count_s1 <= count_next;
		end
	end

	// decide on the window as it stands after this byte shifted in
	assign start = count_s1 - COUNT_W'(len_q);

	always_comb begin
		hit = valid_s1 && !match_reported_q && (count_s1 >= COUNT_W'(len_q)) && all_ok
			&& (count_s1 != COUNT_MAX) && (32'(start) < 32'(MAX_BUFFER))
			&& !start[COUNT_W-1];
		res_s1 = hit || (valid_s1 && last_s1 && !match_reported_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_reported_q <= 1'b0;
		end else if (valid_s1 && s1_go) begin
			if (last_s1) begin
				match_reported_q <= 1'b0;
			end else if (hit) begin
				match_reported_q <= 1'b1;
			end
		end
	end

	// output register; not-found carries offset zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_s1 && s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1 && s1_go) begin
			found_q  <= hit;
			offset_q <= hit ? start[OFFSET_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
	import mbps_pkg::*;
;

	// run shape
	localparam int PHASES        = 9;    // configuration phases
	localparam int PHASE_BYTES   = 75;   // bytes streamed per configuration
	localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
	localparam int SETTLE_CYCLES = 8;    // quiet cycles after the last result
	localparam int QUIET_LIMIT   = 2000; // watchdog: cycles with no transaction

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} scan_result_t;

	// expected-result store plus a bit-true predictor of the scanner
	class search_scoreboard;
		pat_bytes_t          pat;
		logic [PAT_SLOTS-1:0] care;
		logic [LEN_W-1:0]    len_code;
		logic [BYTE_W-1:0]   window [PAT_SLOTS];
		logic [COUNT_W-1:0]  seen;
		bit                  reported;
		scan_result_t        pending_hits[$];
		int                  errors;

		function new();
			pat      = '0;
			care     = '0;
			len_code = 5'd1;
			errors   = 0;
			clear_buffer();
		endfunction

		function void clear_buffer();
			foreach (window[i]) window[i] = '0;
			seen     = '0;
			reported = 1'b0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_PAT_LOW:  pat[7:0]   = value;
				REG_PAT_MID:  pat[15:8]  = value;
				REG_PAT_HIGH: pat[23:16] = value;
				REG_CARE:     care       = value[PAT_SLOTS-1:0];
				REG_LEN:      len_code   = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// zero counts as one, anything past the slot count is clipped
		function int used_len();
			if (len_code == 0)
				return 1;
			if (len_code > PAT_SLOTS)
				return PAT_SLOTS;
			return int'(len_code);
		endfunction

		function void take_byte(logic [BYTE_W-1:0] value, logic is_last);
			int plen;
			int start;
			bit hit;
			plen = used_len();
			for (int i = PAT_SLOTS - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = value;
			if (seen != COUNT_MAX)
				seen++;
			if (!reported && int'(seen) >= plen) begin
				start = int'(seen) - plen;
				hit   = 1'b1;
				for (int j = 0; j < plen; j++)
					if (care[j] && pat[j] != window[plen-1-j])
						hit = 1'b0;
				// no report once the count is pinned or the start is out of range
				if (hit && seen != COUNT_MAX && start < MAX_BUFFER && start <= 16'hFFFF) begin
					pending_hits.push_back('{found: 1'b1, offset: start[OFFSET_W-1:0]});
					reported = 1'b1;
				end
			end
			if (is_last) begin
				if (!reported)
					pending_hits.push_back('{found: 1'b0, offset: '0});
				clear_buffer();
			end
		endfunction

		function void check_hit(logic got_found, logic [OFFSET_W-1:0] got_offset);
			scan_result_t want;
			if (pending_hits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing expected: found=%0b offset=%0d",
						$realtime, got_found, got_offset);
				return;
			end
			want = pending_hits.pop_front();
			if (got_found !== want.found || got_offset !== want.offset) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
						$realtime, want.found, want.offset, got_found, got_offset);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [BYTE_W-1:0]     data_byte;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic                  found;
	logic [OFFSET_W-1:0]   match_offset;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	search_scoreboard sb;

	// shared between the stimulus, the receiver and the monitor
	bit no_idle   = 1'b0; // both sides run without gaps
	bit hold_req  = 1'b0; // ask the receiver for one long hold-off
	bit armed     = 1'b0; // receiver already drew a stall for the waiting result
	int quiet_cycles = 0;

	masked_byte_pattern_search_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.match_offset(match_offset),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor: every accepted transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_hit(found, match_offset);
			armed = 1'b0;
		end
	end

	// receiver: a fresh random stall for each result, or the long hold on request;
	// a running hold is never cut short by a new draw
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (out_valid && !armed && stall_left == 0) begin
				armed      = 1'b1;
				stall_left = no_idle ? 0 : $urandom_range(0, 9);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// watchdog: too long without any transaction means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// byte values biased toward the pattern alphabet so partial matches happen
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h3F; // '?'
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one byte transaction, with a random gap in front
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= value;
		last_byte <= is_last;
		do @(posedge clk); while (in_stall);
		sb.take_byte(value, is_last);
	endtask

	// stop sending, wait for every expected result, then let the pipe go quiet
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	// phase 0 and 1 are the all-ones / all-zeros extremes, 2 to 4 push the
	// length code out of range, the rest are fully random
	task automatic load_phase_config(input int k);
		pat_bytes_t           p;
		logic [PAT_SLOTS-1:0] c;
		logic [LEN_W-1:0]     l;
		for (int j = 0; j < PAT_SLOTS; j++)
			p[j] = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : pick_byte();
		case (k)
			0: begin
				c = '1;
				l = 5'd1;
			end
			1: begin
				c = '1;
				l = 5'd24;
			end
			2: begin
				c = PAT_SLOTS'($urandom_range(0, 24'hFFFFFF));
				l = 5'd31;
			end
			3: begin
				c = '0;
				l = 5'd0;
			end
			4: begin
				c = PAT_SLOTS'($urandom_range(0, 24'hFFFFFF));
				l = 5'd25;
			end
			default: begin
				c = PAT_SLOTS'($urandom_range(0, 24'hFFFFFF));
				l = LEN_W'($urandom_range(1, 24));
			end
		endcase
		write_reg(REG_PAT_LOW, p[7:0]);
		write_reg(REG_PAT_MID, p[15:8]);
		write_reg(REG_PAT_HIGH, p[23:16]);
		write_reg(REG_CARE, {{(CFG_DATA_W-PAT_SLOTS){1'b0}}, c});
		write_reg(REG_LEN, {{(CFG_DATA_W-LEN_W){1'b0}}, l});
	endtask

	// one buffer of random content; most of them carry a planted copy of the
	// pattern (wildcard slots stay random), sometimes cut off by the buffer end
	task automatic send_buffer(inout int sent);
		logic [BYTE_W-1:0] bytes[$];
		int n;
		int at;
		int plen;
		plen = sb.used_len();
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, plen + 12);
		for (int i = 0; i < n; i++)
			bytes.push_back(pick_byte());
		if ($urandom_range(0, 3) != 0) begin
			at = $urandom_range(0, n - 1);
			for (int j = 0; j < plen && at + j < n; j++)
				if (sb.care[j])
					bytes[at+j] = sb.pat[j];
		end
		for (int i = 0; i < n; i++)
			send_byte(bytes[i], i == n - 1);
		sent += n;
	endtask

	initial begin
		int sent;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setup: one wildcard byte, so the first byte of any buffer hits
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1); // after the hit, ignored up to the end
		drain_results();

		// four-byte pattern ff ?? 00 80, slot 1 wildcard, care bits past the
		// length set to show they are ignored
		write_reg(REG_PAT_LOW, 64'h0000_0000_8000_3FFF);
		write_reg(REG_PAT_MID, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PAT_HIGH, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_CARE, 64'h0000_0000_00FF_FFFD);
		write_reg(REG_LEN, 64'd4);
		// buffer shorter than the pattern
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		// match completing on the last byte
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
		// near miss, not found
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h81, 1'b1);
		// hit at offset 0, the rest of the buffer is ignored
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h66, 1'b1);
		drain_results();

		// length code 0 behaves as a one-byte pattern
		write_reg(REG_PAT_LOW, 64'h3F);
		write_reg(REG_CARE, 64'h1);
		write_reg(REG_LEN, 64'd0);
		send_byte(8'h3E, 1'b0);
		send_byte(8'h3F, 1'b1);
		drain_results();

		// back-pressure: every one-byte buffer gives a hit while the receiver
		// holds off, so the output and compare stages fill and the input stalls
		write_reg(REG_CARE, 64'h0);
		write_reg(REG_LEN, 64'd1);
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_byte(pick_byte(), 1'b1);
		drain_results(); // sender waits for every result

		// random part: a fresh configuration per phase, buffers with random content
		for (int k = 0; k < PHASES; k++) begin
			load_phase_config(k);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				no_idle = ($urandom_range(0, 4) == 0);
				send_buffer(sent);
			end
			no_idle = 1'b0;
			drain_results();
		end

		if (sb.errors == 0 && sb.pending_hits.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
